### hw/rtl/owvc_pkg.sv
package owvc_pkg;

  // Sizing
  localparam int MAX_WHEELS  = 8;
  localparam int ANGLE_BITS  = 16;
  localparam int WHEEL_LIMIT = (MAX_WHEELS < 8) ? MAX_WHEELS : 8;
  localparam int WHEEL_W     = (WHEEL_LIMIT > 1) ? $clog2(WHEEL_LIMIT) : 1;
  localparam int COUNT_W     = 4;
  localparam int ANGLE_KEEP  = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
  localparam logic [15:0] ANGLE_MASK =
    16'(~((32'd1 << (16 - ANGLE_KEEP)) - 32'd1));

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WHEEL_COUNT      = 3'd0,
    REG_ANGLE_STEP       = 3'd1,
    REG_ANGLE_OFFSET     = 3'd2,
    REG_BODY_RADIUS      = 3'd3,
    REG_INV_WHEEL_RADIUS = 3'd4,
    REG_COMMAND_TIMEOUT  = 3'd5
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0] WHEEL_COUNT_RESET = 4'd3;
  localparam logic [15:0]        ANGLE_STEP_RESET  = 16'd21845;
  localparam logic [15:0]        ANGLE_OFFSET_RESET = 16'd0;
  localparam logic [31:0]        RADIUS_RESET      = 32'd65536;
  localparam logic [31:0]        INV_RADIUS_RESET  = 32'd65536;
  localparam logic [31:0]        TIMEOUT_RESET     = 32'd0;

  // Sine polynomial, Q30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] SIN_C1  = 31'd1686629713;
  localparam logic [30:0] SIN_C3  = 31'd693598668;
  localparam logic [30:0] SIN_C5  = 31'd85569305;
  localparam logic [30:0] SIN_C7  = 31'd5026995;
  localparam logic [30:0] SIN_C9  = 31'd172272;

  // Microcode
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_WHEEL = 5'd2;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_YAW,
    MUL_XX,
    MUL_HORNER,
    MUL_XP,
    MUL_SVX,
    MUL_CVY,
    MUL_MLO,
    MUL_MHI
  } mul_op_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_YAW,
    WB_LOADX,
    WB_X2,
    WB_C7,
    WB_C5,
    WB_C3,
    WB_C1,
    WB_TRIG,
    WB_LIN_LOAD,
    WB_LIN_SUB,
    WB_LINQ,
    WB_MAG,
    WB_ACC_LOAD,
    WB_ACC_ADD,
    WB_EMIT
  } wb_op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_TRIG,
    COND_EMIT
  } cond_t;

  typedef struct packed {
    mul_op_t mul;
    wb_op_t  wb;
    cond_t   cond;
    step_t   target;
  } ctrl_word_t;

  function automatic ctrl_word_t cw(mul_op_t m, wb_op_t w, cond_t c, step_t t);
    ctrl_word_t r;
    r.mul    = m;
    r.wb     = w;
    r.cond   = c;
    r.target = t;
    return r;
  endfunction

  // Product issued in one step is written back in the next.
  function automatic ctrl_word_t ucode(step_t pc);
    ctrl_word_t r;
    case (pc)
      5'd0:    r = cw(MUL_YAW,    WB_NONE,     COND_NEXT, '0);
      5'd1:    r = cw(MUL_NONE,   WB_YAW,      COND_NEXT, '0);
      5'd2:    r = cw(MUL_NONE,   WB_LOADX,    COND_NEXT, '0);
      5'd3:    r = cw(MUL_XX,     WB_NONE,     COND_NEXT, '0);
      5'd4:    r = cw(MUL_NONE,   WB_X2,       COND_NEXT, '0);
      5'd5:    r = cw(MUL_HORNER, WB_NONE,     COND_NEXT, '0);
      5'd6:    r = cw(MUL_NONE,   WB_C7,       COND_NEXT, '0);
      5'd7:    r = cw(MUL_HORNER, WB_NONE,     COND_NEXT, '0);
      5'd8:    r = cw(MUL_NONE,   WB_C5,       COND_NEXT, '0);
      5'd9:    r = cw(MUL_HORNER, WB_NONE,     COND_NEXT, '0);
      5'd10:   r = cw(MUL_NONE,   WB_C3,       COND_NEXT, '0);
      5'd11:   r = cw(MUL_HORNER, WB_NONE,     COND_NEXT, '0);
      5'd12:   r = cw(MUL_NONE,   WB_C1,       COND_NEXT, '0);
      5'd13:   r = cw(MUL_XP,     WB_NONE,     COND_NEXT, '0);
      5'd14:   r = cw(MUL_NONE,   WB_TRIG,     COND_TRIG, STEP_WHEEL);
      5'd15:   r = cw(MUL_SVX,    WB_NONE,     COND_NEXT, '0);
      5'd16:   r = cw(MUL_CVY,    WB_LIN_LOAD, COND_NEXT, '0);
      5'd17:   r = cw(MUL_NONE,   WB_LIN_SUB,  COND_NEXT, '0);
      5'd18:   r = cw(MUL_NONE,   WB_LINQ,     COND_NEXT, '0);
      5'd19:   r = cw(MUL_NONE,   WB_MAG,      COND_NEXT, '0);
      5'd20:   r = cw(MUL_MLO,    WB_NONE,     COND_NEXT, '0);
      5'd21:   r = cw(MUL_MHI,    WB_ACC_LOAD, COND_NEXT, '0);
      5'd22:   r = cw(MUL_NONE,   WB_ACC_ADD,  COND_NEXT, '0);
      5'd23:   r = cw(MUL_NONE,   WB_EMIT,     COND_EMIT, STEP_WHEEL);
      default: r = cw(MUL_NONE,   WB_NONE,     COND_NEXT, '0);
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/owvc_if.sv
interface owvc_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cmd_linear_x;
  logic signed [31:0] cmd_linear_y;
  logic signed [31:0] cmd_angular_z;
  logic [31:0]        command_age;
  logic               command_finite;

  modport source (
    output valid, cmd_linear_x, cmd_linear_y, cmd_angular_z, command_age, command_finite,
    input  ready
  );
  modport sink (
    input  valid, cmd_linear_x, cmd_linear_y, cmd_angular_z, command_age, command_finite,
    output ready
  );
endinterface

interface owvc_wheel_if;
  logic               valid;
  logic               ready;
  logic [2:0]         wheel_index;
  logic signed [31:0] wheel_velocity;
  logic               saturated;
  logic               last_wheel;

  modport source (
    output valid, wheel_index, wheel_velocity, saturated, last_wheel,
    input  ready
  );
  modport sink (
    input  valid, wheel_index, wheel_velocity, saturated, last_wheel,
    output ready
  );
endinterface

### hw/rtl/omni_wheel_velocity_command.sv
// Omni-wheel inverse kinematics. Each command item is one control tick: it refreshes
// the held body velocity reference (zeroed when command_age exceeds command_timeout,
// replaced by a finite command, kept otherwise) and then emits one wheel item per
// wheel, wheel 0 first, last_wheel set on the final one. No items come out until a
// reference has been set since reset, or when wheel_count is 0. The work runs on one
// shared 33x33 multiplier driven by a 24-step microprogram: setup steps once per tick,
// then per wheel a sine and a cosine polynomial pass and the velocity steps. cmd.ready
// stays low from the accepting edge until the last wheel item is emitted. A finished
// wheel item sits in an output register; the sequencer stalls only if the previous one
// has not yet been taken. Configuration is to be written only while the block is idle.
module omni_wheel_velocity_command (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [owvc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [owvc_pkg::CFG_DATA_W-1:0]  cfg_data,
  owvc_cmd_if.sink                         cmd,
  owvc_wheel_if.source                     wheel
);
  import owvc_pkg::*;

  // Configuration
  logic [COUNT_W-1:0] wheel_count;
  logic [15:0]        angle_step;
  logic [15:0]        angle_offset;
  logic [31:0]        body_radius;
  logic [31:0]        inv_wheel_radius;
  logic [31:0]        command_timeout;

  // Held reference
  logic [31:0] ref_x, ref_y, ref_yaw;
  logic        ref_valid;
  logic        ref_valid_next;

  // Sequencer
  step_t      pc, pc_next;
  logic       busy, busy_next;
  logic       cos_pass, cos_pass_next;
  ctrl_word_t ctrl;
  logic       in_fire, start, advance, emit_fire;

  // Datapath
  logic [WHEEL_W-1:0] wheel_num;
  logic [15:0]        angle;
  logic [COUNT_W-1:0] n_eff;
  logic               is_last;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [31:0]        wz_mag;
  logic [47:0]        yaw_round;
  logic signed [47:0] yawq;
  logic [15:0]        angle_q;
  logic [1:0]         quad_sel, quad;
  logic [30:0]        frac, x_fold;
  logic [30:0]        x, x2, p;
  logic [30:0]        horner;
  logic signed [31:0] trig_val;
  logic signed [31:0] s, c;
  logic signed [63:0] lin;
  logic [63:0]        lin_mag;
  logic [33:0]        linq_mag;
  logic signed [34:0] linq;
  logic signed [48:0] v_val;
  logic [47:0]        m;
  logic               v_neg;
  logic [79:0]        acc;
  logic [63:0]        tot;
  logic               sat_calc;
  logic [31:0]        vel_calc;

  logic               out_valid;
  logic [2:0]         out_index;
  logic [31:0]        out_vel;
  logic               out_sat;
  logic               out_last;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_count      <= WHEEL_COUNT_RESET;
      angle_step       <= ANGLE_STEP_RESET;
      angle_offset     <= ANGLE_OFFSET_RESET;
      body_radius      <= RADIUS_RESET;
      inv_wheel_radius <= INV_RADIUS_RESET;
      command_timeout  <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WHEEL_COUNT:      wheel_count      <= cfg_data[COUNT_W-1:0];
        REG_ANGLE_STEP:       angle_step       <= cfg_data[15:0];
        REG_ANGLE_OFFSET:     angle_offset     <= cfg_data[15:0];
        REG_BODY_RADIUS:      body_radius      <= cfg_data[31:0];
        REG_INV_WHEEL_RADIUS: inv_wheel_radius <= cfg_data[31:0];
        REG_COMMAND_TIMEOUT:  command_timeout  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_fire = cmd.valid && cmd.ready;
  assign cmd.ready = !busy;

  assign n_eff = (wheel_count > COUNT_W'(WHEEL_LIMIT)) ? COUNT_W'(WHEEL_LIMIT) : wheel_count;

  always_comb begin
    ref_valid_next = ref_valid;
    if (cmd.command_age > command_timeout || cmd.command_finite) begin
      ref_valid_next = 1'b1;
    end
  end

  assign start = in_fire && ref_valid_next && (n_eff != '0);

  // Reference update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x     <= '0;
      ref_y     <= '0;
      ref_yaw   <= '0;
      ref_valid <= 1'b0;
    end else if (in_fire) begin
      ref_valid <= ref_valid_next;
      if (cmd.command_age > command_timeout) begin
        ref_x   <= '0;
        ref_y   <= '0;
        ref_yaw <= '0;
      end else if (cmd.command_finite) begin
        ref_x   <= cmd.cmd_linear_x;
        ref_y   <= cmd.cmd_linear_y;
        ref_yaw <= cmd.cmd_angular_z;
      end
    end
  end

  // Microsequencer
  assign ctrl      = ucode(pc);
  assign is_last   = (COUNT_W'(wheel_num) + COUNT_W'(1)) == n_eff;
  assign advance   = busy && !(ctrl.cond == COND_EMIT && out_valid && !wheel.ready);
  assign emit_fire = advance && ctrl.wb == WB_EMIT;

  always_comb begin
    pc_next       = pc;
    busy_next     = busy;
    cos_pass_next = cos_pass;
    if (!busy) begin
      pc_next       = '0;
      cos_pass_next = 1'b0;
      busy_next     = start;
    end else if (advance) begin
      case (ctrl.cond)
        COND_TRIG: begin
          if (!cos_pass) begin
            pc_next       = ctrl.target;
            cos_pass_next = 1'b1;
          end else begin
            pc_next       = step_t'(pc + 5'd1);
            cos_pass_next = 1'b0;
          end
        end
        COND_EMIT: begin
          if (is_last) begin
            pc_next   = '0;
            busy_next = 1'b0;
          end else begin
            pc_next = ctrl.target;
          end
        end
        default: pc_next = step_t'(pc + 5'd1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      busy     <= 1'b0;
      cos_pass <= 1'b0;
    end else begin
      pc       <= pc_next;
      busy     <= busy_next;
      cos_pass <= cos_pass_next;
    end
  end

  // Multiplier operand select
  assign wz_mag = ref_yaw[31] ? 32'(-ref_yaw) : ref_yaw;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      MUL_YAW: begin
        mul_a = {1'b0, wz_mag};
        mul_b = {1'b0, body_radius};
      end
      MUL_XX: begin
        mul_a = {2'b0, x};
        mul_b = {2'b0, x};
      end
      MUL_HORNER: begin
        mul_a = {2'b0, x2};
        mul_b = {2'b0, p};
      end
      MUL_XP: begin
        mul_a = {2'b0, x};
        mul_b = {2'b0, p};
      end
      MUL_SVX: begin
        mul_a = {s[31], s};
        mul_b = {ref_x[31], ref_x};
      end
      MUL_CVY: begin
        mul_a = {c[31], c};
        mul_b = {ref_y[31], ref_y};
      end
      MUL_MLO: begin
        mul_a = {1'b0, m[31:0]};
        mul_b = {1'b0, inv_wheel_radius};
      end
      MUL_MHI: begin
        mul_a = {17'b0, m[47:32]};
        mul_b = {1'b0, inv_wheel_radius};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (busy && ctrl.mul != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  // Write-back arithmetic
  always_comb begin
    angle_q   = angle & ANGLE_MASK;
    quad_sel  = angle_q[15:14] + {1'b0, cos_pass};
    frac      = {1'b0, angle_q[13:0], 16'b0};
    x_fold    = quad_sel[0] ? (Q30_ONE - frac) : frac;
    horner    = prod[60:30];
    yaw_round = 48'((prod[63:0] + 64'h8000) >> 16);
    trig_val  = quad[1] ? -$signed({1'b0, horner}) : $signed({1'b0, horner});
    lin_mag   = lin[63] ? 64'(-lin) : 64'(lin);
    linq_mag  = 34'((lin_mag + 64'h2000_0000) >> 30);
    v_val     = {{14{linq[34]}}, linq} - {yawq[47], yawq};
    tot       = acc[79:16];
    if (v_neg) begin
      sat_calc = tot > 64'h8000_0000;
      vel_calc = sat_calc ? 32'h8000_0000 : 32'(-tot[31:0]);
    end else begin
      sat_calc = tot > 64'h7FFF_FFFF;
      vel_calc = sat_calc ? 32'h7FFF_FFFF : tot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      angle     <= angle_offset;
      wheel_num <= '0;
    end
    if (busy) begin
      case (ctrl.wb)
        WB_YAW:   yawq <= ref_yaw[31] ? -$signed(yaw_round) : $signed(yaw_round);
        WB_LOADX: begin
          quad <= quad_sel;
          x    <= x_fold;
        end
        WB_X2: begin
          x2 <= horner;
          p  <= SIN_C9;
        end
        WB_C7: p <= SIN_C7 - horner;
        WB_C5: p <= SIN_C5 - horner;
        WB_C3: p <= SIN_C3 - horner;
        WB_C1: p <= SIN_C1 - horner;
        WB_TRIG: begin
          if (cos_pass) c <= trig_val;
          else s <= trig_val;
        end
        WB_LIN_LOAD: lin <= prod[63:0];
        WB_LIN_SUB:  lin <= lin - prod[63:0];
        WB_LINQ:     linq <= lin[63] ? -$signed({1'b0, linq_mag}) : $signed({1'b0, linq_mag});
        WB_MAG: begin
          m     <= v_val[48] ? 48'(-v_val) : v_val[47:0];
          v_neg <= v_val[48];
        end
        WB_ACC_LOAD: acc <= {16'b0, prod[63:0]} + 80'h8000;
        WB_ACC_ADD:  acc <= acc + {prod[47:0], 32'b0};
        WB_EMIT: begin
          if (emit_fire) begin
            // step to the next wheel
            angle     <= angle + angle_step;
            wheel_num <= wheel_num + WHEEL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (wheel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_index <= 3'(wheel_num);
      out_vel   <= vel_calc;
      out_sat   <= sat_calc;
      out_last  <= is_last;
    end
  end

  assign wheel.valid          = out_valid;
  assign wheel.wheel_index    = out_index;
  assign wheel.wheel_velocity = out_vel;
  assign wheel.saturated      = out_sat;
  assign wheel.last_wheel     = out_last;

  // Checks
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !wheel.valid)
    else $error("block not idle after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> !(out_valid && !wheel.ready))
    else $error("wheel item overwritten before taken");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    busy && ctrl.wb == WB_X2 |-> x <= Q30_ONE)
    else $error("folded phase beyond a quarter turn");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (rst)
    emit_fire && is_last |=> !busy && pc == '0)
    else $error("sequencer still busy after last wheel");

endmodule

### tb/omni_wheel_velocity_command_tb.sv
`timescale 1ns / 100ps

module omni_wheel_velocity_command_tb;
  import owvc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = 2 + 35 * 8 + 20;
  localparam int ITEMS_PER_PHASE = 19;
  localparam int RANDOM_PHASES   = 8;
  localparam int REPORT_CAP      = 40;

  localparam logic signed [31:0] VEL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VEL_MIN = 32'sh8000_0000;
  localparam logic [31:0]        AGE_MAX = 32'hFFFF_FFFF;

  // Indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

  typedef struct {
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] yaw;
    logic [31:0]        age;
    logic               finite;
  } body_cmd_t;

  typedef struct {
    logic [2:0]         index;
    logic signed [31:0] speed;
    logic               clipped;
    logic               last;
  } wheel_cmd_t;

  class omni_wheel_board;
    localparam int          WHEELS_MAX   = 8;
    localparam bit [63:0]   QUARTER      = 64'h4000_0000;
    localparam bit [31:0]   QUARTER_TURN = 32'h4000_0000;
    localparam bit [63:0]   SINE_K1      = 64'd1686629713;
    localparam bit [63:0]   SINE_K3      = 64'd693598668;
    localparam bit [63:0]   SINE_K5      = 64'd85569305;
    localparam bit [63:0]   SINE_K7      = 64'd5026995;
    localparam bit [63:0]   SINE_K9      = 64'd172272;

    bit [3:0]  count;
    bit [15:0] step;
    bit [15:0] offset;
    bit [31:0] radius;
    bit [31:0] inv_radius;
    bit [31:0] timeout;

    bit signed [31:0] hold_x;
    bit signed [31:0] hold_y;
    bit signed [31:0] hold_yaw;
    bit               hold_valid;

    wheel_cmd_t expected_wheels[$];
    int mismatches;
    int ticks;
    int wheels_checked;
    int clipped_seen;

    function new();
      count      = WHEEL_COUNT_RESET;
      step       = ANGLE_STEP_RESET;
      offset     = ANGLE_OFFSET_RESET;
      radius     = RADIUS_RESET;
      inv_radius = INV_RADIUS_RESET;
      timeout    = TIMEOUT_RESET;
      hold_x     = '0;
      hold_y     = '0;
      hold_yaw   = '0;
      hold_valid = 1'b0;
    endfunction

    function void set_register(bit [CFG_INDEX_W-1:0] index, bit [31:0] data);
      case (index)
        REG_WHEEL_COUNT:      count = data[3:0];
        REG_ANGLE_STEP:       step = data[15:0];
        REG_ANGLE_OFFSET:     offset = data[15:0];
        REG_BODY_RADIUS:      radius = data;
        REG_INV_WHEEL_RADIUS: inv_radius = data;
        REG_COMMAND_TIMEOUT:  timeout = data;
        default: ;
      endcase
    endfunction

    // Q30 sine over a 32-bit turn phase, quarter-wave polynomial
    function longint signed sine_q30(bit [31:0] phase);
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] p;
      x = phase[29:0];
      if (phase[30]) x = QUARTER - x;
      x2 = (x * x) >> 30;
      p = SINE_K9;
      p = SINE_K7 - ((x2 * p) >> 30);
      p = SINE_K5 - ((x2 * p) >> 30);
      p = SINE_K3 - ((x2 * p) >> 30);
      p = SINE_K1 - ((x2 * p) >> 30);
      p = (x * p) >> 30;
      return phase[31] ? -$signed(p) : $signed(p);
    endfunction

    function void note_command(body_cmd_t c);
      int unsigned      wheels;
      longint signed    vx, vy, wz, yaw_q, sin_v, cos_v, lin, lin_q, diff, res;
      bit [63:0]        mag, ym, prod, total;
      bit [15:0]        ang;
      bit [31:0]        phase;
      wheel_cmd_t       w;
      ticks++;
      if (c.age > timeout) begin
        hold_x     = '0;
        hold_y     = '0;
        hold_yaw   = '0;
        hold_valid = 1'b1;
      end else if (c.finite) begin
        hold_x     = c.lin_x;
        hold_y     = c.lin_y;
        hold_yaw   = c.yaw;
        hold_valid = 1'b1;
      end
      if (!hold_valid) return;

      wheels = (count > WHEELS_MAX) ? WHEELS_MAX : count;
      vx = hold_x;
      vy = hold_y;
      wz = hold_yaw;
      mag = (wz < 0) ? -wz : wz;
      ym = (mag * radius + 64'h8000) >> 16;
      yaw_q = (wz < 0) ? -$signed(ym) : $signed(ym);

      for (int i = 0; i < wheels; i++) begin
        ang = 16'(i * step + offset);
        phase = {ang, 16'h0000};
        sin_v = sine_q30(phase);
        cos_v = sine_q30(phase + QUARTER_TURN);
        lin = sin_v * vx - cos_v * vy;
        mag = (lin < 0) ? -lin : lin;
        lin_q = (mag + (64'd1 << 29)) >> 30;
        if (lin < 0) lin_q = -lin_q;
        diff = lin_q - yaw_q;
        mag = (diff < 0) ? -diff : diff;
        // integer part of the reciprocal first; cap keeps the sum from wrapping
        prod = mag * inv_radius[31:16];
        if (prod > (64'd1 << 40)) total = 64'd1 << 40;
        else total = prod + ((mag * inv_radius[15:0] + 64'h8000) >> 16);
        w.clipped = 1'b0;
        if (diff < 0) begin
          if (total > 64'h8000_0000) begin
            total = 64'h8000_0000;
            w.clipped = 1'b1;
          end
          res = -$signed(total);
        end else begin
          if (total > 64'h7FFF_FFFF) begin
            total = 64'h7FFF_FFFF;
            w.clipped = 1'b1;
          end
          res = $signed(total);
        end
        w.index = 3'(i);
        w.speed = res[31:0];
        w.last  = (i + 1 == wheels);
        expected_wheels.insert(expected_wheels.size(), w);
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("%0t: wheel mismatch: %s", $time, what);
    endtask

    task check_wheel(wheel_cmd_t got);
      wheel_cmd_t want;
      if (expected_wheels.size() == 0) begin
        report($sformatf("unexpected item, index %0d velocity %0d", got.index, got.speed));
        return;
      end
      want = expected_wheels.pop_front();
      wheels_checked++;
      if (got.clipped === 1'b1) clipped_seen++;
      if (got.index !== want.index)
        report($sformatf("wheel_index %0d, want %0d", got.index, want.index));
      if (got.speed !== want.speed)
        report($sformatf("wheel %0d velocity %0d, want %0d", want.index, got.speed,
                         want.speed));
      if (got.clipped !== want.clipped)
        report($sformatf("wheel %0d saturated %b, want %b", want.index, got.clipped,
                         want.clipped));
      if (got.last !== want.last)
        report($sformatf("wheel %0d last_wheel %b, want %b", want.index, got.last,
                         want.last));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  owvc_cmd_if   cmd();
  owvc_wheel_if wheel();

  omni_wheel_velocity_command dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .wheel     (wheel)
  );

  omni_wheel_board board;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int reg_writes;
  int settings_used;
  body_cmd_t  seen_cmd;
  wheel_cmd_t seen_wheel;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    wheel.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Observe both channels and watch for a stuck block
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        seen_cmd.lin_x  = cmd.cmd_linear_x;
        seen_cmd.lin_y  = cmd.cmd_linear_y;
        seen_cmd.yaw    = cmd.cmd_angular_z;
        seen_cmd.age    = cmd.command_age;
        seen_cmd.finite = cmd.command_finite;
        board.note_command(seen_cmd);
      end
      if (wheel.valid && wheel.ready) begin
        seen_wheel.index   = wheel.wheel_index;
        seen_wheel.speed   = wheel.wheel_velocity;
        seen_wheel.clipped = wheel.saturated;
        seen_wheel.last    = wheel.last_wheel;
        board.check_wheel(seen_wheel);
      end
      if ((cmd.valid && cmd.ready) || (wheel.valid && wheel.ready) || cfg_write) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("omni_wheel_velocity_command_tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic body_cmd_t tick(logic signed [31:0] lx, logic signed [31:0] ly,
                                     logic signed [31:0] yr, logic [31:0] age,
                                     logic finite);
    body_cmd_t c;
    c.lin_x  = lx;
    c.lin_y  = ly;
    c.yaw    = yr;
    c.age    = age;
    c.finite = finite;
    return c;
  endfunction

  function automatic logic signed [31:0] random_speed();
    int unsigned        pick;
    logic signed [31:0] v;
    pick = $urandom_range(9);
    if (pick < 6) begin
      v = $urandom_range(32'h0008_0000);
      if ($urandom_range(1)) v = -v;
    end else if (pick < 9) begin
      v = $urandom;
    end else begin
      case ($urandom_range(2))
        0:       v = VEL_MAX;
        1:       v = VEL_MIN;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  task automatic send_command(body_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid          <= 1'b1;
    cmd.cmd_linear_x   <= c.lin_x;
    cmd.cmd_linear_y   <= c.lin_y;
    cmd.cmd_angular_z  <= c.yaw;
    cmd.command_age    <= c.age;
    cmd.command_finite <= c.finite;
    @(posedge clk);
    while (cmd.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    board.set_register(index, data);
    reg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, drain all expected wheels, then give the sequencer time to go idle
  task automatic settle();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_wheels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [3:0]  cnt;
    body_cmd_t   c;
    int unsigned pick;

    board = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd.valid = 1'b0;
    cmd.cmd_linear_x = '0;
    cmd.cmd_linear_y = '0;
    cmd.cmd_angular_z = '0;
    cmd.command_age = '0;
    cmd.command_finite = 1'b0;
    wheel.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reg_writes = 0;
    settings_used = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // No reference yet: nothing comes out
    send_command(tick(VEL_MAX, VEL_MIN, VEL_MAX, '0, 1'b0));
    send_command(tick('0, '0, '0, '0, 1'b0));
    send_command(tick(32'sh0001_0000, '0, '0, '0, 1'b1));
    // non-finite keeps the held reference
    send_command(tick(VEL_MIN, VEL_MAX, VEL_MIN, '0, 1'b0));
    // zero timeout: any nonzero age clears the reference
    send_command(tick(VEL_MAX, VEL_MAX, VEL_MAX, 32'd1, 1'b1));
    send_command(tick(VEL_MIN, VEL_MIN, VEL_MIN, '0, 1'b1));
    send_command(tick(VEL_MAX, VEL_MIN, '0, '0, 1'b1));
    send_command(tick(32'sd1, -32'sd1, 32'sd1, '0, 1'b1));
    settle();

    write_reg(REG_WHEEL_COUNT, 32'd8);
    write_reg(REG_ANGLE_STEP, 32'd8192);
    write_reg(REG_ANGLE_OFFSET, 32'h0000_FFFF);
    write_reg(REG_BODY_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_INV_WHEEL_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_COMMAND_TIMEOUT, 32'hFFFF_FFFF);
    settings_used++;
    send_command(tick('0, '0, VEL_MAX, AGE_MAX, 1'b1));
    send_command(tick('0, '0, VEL_MIN, AGE_MAX, 1'b1));
    send_command(tick(VEL_MAX, VEL_MIN, '0, '0, 1'b1));
    send_command(tick(32'sh0000_0100, '0, '0, '0, 1'b1));
    settle();

    // count above the limit clamps; zero radii give all-zero velocities
    write_reg(REG_WHEEL_COUNT, 32'd15);
    write_reg(REG_ANGLE_STEP, 32'd65535);
    write_reg(REG_ANGLE_OFFSET, 32'd0);
    write_reg(REG_BODY_RADIUS, 32'd0);
    write_reg(REG_INV_WHEEL_RADIUS, 32'd0);
    write_reg(REG_COMMAND_TIMEOUT, 32'd100);
    settings_used++;
    send_command(tick(VEL_MAX, VEL_MAX, VEL_MAX, 32'd100, 1'b1));
    send_command(tick(32'sd1, 32'sd1, 32'sd1, 32'd101, 1'b1));
    settle();

    write_reg(REG_WHEEL_COUNT, 32'd0);
    write_reg(REG_INV_WHEEL_RADIUS, 32'h0001_8000);
    settings_used++;
    send_command(tick(32'sh0002_0000, 32'sh0001_0000, '0, '0, 1'b1));
    settle();

    // writes to unused indexes must leave every register alone
    write_reg(REG_WHEEL_COUNT, 32'd1);
    write_reg(REG_ANGLE_STEP, 32'd0);
    write_reg(REG_ANGLE_OFFSET, 32'h0000_4000);
    write_reg(REG_BODY_RADIUS, 32'h0002_0000);
    write_reg(SPARE_INDEX_LO, 32'd0);
    write_reg(SPARE_INDEX_HI, 32'hFFFF_FFFF);
    settings_used++;
    send_command(tick(32'sh0003_0000, -32'sh0002_0000, 32'sh0000_8000, 32'd5, 1'b1));
    send_command(tick(VEL_MAX, VEL_MAX, VEL_MAX, 32'd7, 1'b0));
    settle();

    write_reg(REG_WHEEL_COUNT, 32'd2);
    write_reg(REG_ANGLE_STEP, 32'd32768);
    write_reg(REG_ANGLE_OFFSET, 32'h0000_2000);
    settings_used++;
    send_command(tick(-32'sh0001_8000, 32'sh0000_4000, -32'sd1, '0, 1'b1));
    send_command(tick(VEL_MIN, '0, '0, '0, 1'b1));
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cnt = ($urandom_range(9) < 7) ? 4'($urandom_range(8, 3)) : 4'($urandom_range(15, 0));
      write_reg(REG_WHEEL_COUNT, 32'(cnt));
      write_reg(REG_ANGLE_STEP, (cnt != 0 && $urandom_range(9) < 7) ?
                32'(65536 / cnt) : $urandom_range(65535));
      write_reg(REG_ANGLE_OFFSET, $urandom_range(65535));
      pick = $urandom_range(9);
      write_reg(REG_BODY_RADIUS, (pick < 5) ? $urandom_range(32'h0004_0000) :
                (pick < 8) ? $urandom_range(32'h0100_0000) : $urandom);
      pick = $urandom_range(19);
      write_reg(REG_INV_WHEEL_RADIUS, (pick < 10) ? $urandom_range(32'h0010_0000) :
                (pick < 17) ? $urandom_range(32'h0100_0000) : $urandom);
      pick = $urandom_range(19);
      write_reg(REG_COMMAND_TIMEOUT, (pick < 8) ? $urandom_range(1000) :
                (pick < 14) ? $urandom : (pick < 17) ? 32'd0 : 32'hFFFF_FFFF);
      settings_used++;

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase

      // mostly fresh finite commands within the timeout; some stale, some non-finite
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        c.lin_x  = random_speed();
        c.lin_y  = random_speed();
        c.yaw    = random_speed();
        c.finite = 1'b1;
        c.age    = (board.timeout == 0) ? 32'd0 : $urandom_range(board.timeout, 0);
        if (pick >= 85) c.finite = 1'b0;
        else if (pick >= 72 && board.timeout != AGE_MAX)
          c.age = $urandom_range(AGE_MAX, board.timeout + 1);
        send_command(c);
      end
      settle();
    end

    $display("covered %0d command items and %0d wheel items (%0d saturated)",
             board.ticks, board.wheels_checked, board.clipped_seen);
    $display("%0d register writes over %0d settings, with and without idling on both sides",
             reg_writes, settings_used);
    if (board.mismatches == 0) begin
      $display("omni_wheel_velocity_command_tb: PASS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("omni_wheel_velocity_command_tb: FAIL");
    end
    $finish;
  end

endmodule
